/* rtl/core/u8d_pkg.sv */
package u8d_pkg;

	localparam int BufDepth = 4;
	localparam int CntWidth = 3;
	localparam int CpWidth  = 21;

	localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// Lead byte classes: mask and match pairs.
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} u8d_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // take the input request into the buffer
		logic step;    // apply one decode step, result goes to the hold slot
		logic finish;  // end of the run for this byte, flush the hold slot
	} u8d_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;        // the current decode step gives a result
		logic out_free;    // the output register can take a result this cycle
		logic hold_valid;  // a result waits in the hold slot
	} u8d_sts_t;

endpackage

/* rtl/core/u8d_ctrl.sv */
module u8d_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  u8d_pkg::u8d_sts_t  sts,
	output u8d_pkg::u8d_cmd_t  cmd
);

	u8d_pkg::u8d_state_t state_q;
	u8d_pkg::u8d_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			u8d_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = u8d_pkg::ST_RUN;
				end
			end
			u8d_pkg::ST_RUN: begin
				// A held result must find room in the output register first.
				if (!sts.hold_valid || sts.out_free) begin
					if (sts.emit) begin
						cmd.step = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						state_d    = u8d_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = u8d_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/u8d_dp.sv */
module u8d_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      text_byte,
	input  logic                            final_byte,
	input  u8d_pkg::u8d_cmd_t               cmd,
	output u8d_pkg::u8d_sts_t               sts,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [u8d_pkg::CpWidth-1:0]     code_point,
	output logic                            last_of_run,
	output logic                            end_of_text
);

	localparam int Depth = u8d_pkg::BufDepth;
	localparam int CpW   = u8d_pkg::CpWidth;
	localparam int CntW  = u8d_pkg::CntWidth;
	localparam int IdxW  = $clog2(Depth);

	logic [7:0]      buf_q [Depth];
	logic [7:0]      shifted [Depth];
	logic [CntW-1:0] cnt_q;
	logic            fin_q;
	logic [CpW-1:0]  hold_cp_q;
	logic            hold_valid_q;
	logic            out_valid_q;
	logic [CpW-1:0]  out_cp_q;
	logic            out_last_q;
	logic            out_eot_q;

	logic            dec_emit;
	logic            dec_clear;
	logic [CntW-1:0] dec_drop;
	logic [CpW-1:0]  dec_cp;
	logic [CntW-1:0] dec_len;
	logic            dec_valid_lead;
	logic [2:0]      cont_ok;
	logic            seq_ok;
	logic            out_free;
	logic            push;
	logic [7:0]      lead;

	assign lead = buf_q[0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cont_ok[i] = (buf_q[i+1] & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE;
		end
	end

	// One decode step on the front of the buffer.
	always_comb begin
		dec_emit       = 1'b0;
		dec_clear      = 1'b0;
		dec_drop       = CntW'(1);
		dec_cp         = u8d_pkg::REPLACEMENT_CP;
		dec_len        = CntW'(1);
		dec_valid_lead = 1'b1;
		seq_ok         = 1'b0;
		if ((lead & u8d_pkg::ASCII_MASK) == 8'h00) begin
			dec_len = CntW'(1);
		end else if ((lead & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_CODE) begin
			dec_len = CntW'(2);
		end else if ((lead & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_CODE) begin
			dec_len = CntW'(3);
		end else if ((lead & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_CODE) begin
			dec_len = CntW'(4);
		end else begin
			dec_valid_lead = 1'b0;
		end

		if (cnt_q != '0) begin
			if (!dec_valid_lead) begin
				dec_emit = 1'b1;
			end else if (cnt_q < dec_len) begin
				// Sequence not complete yet; at end of text it is cut short.
				if (fin_q) begin
					dec_emit  = 1'b1;
					dec_clear = 1'b1;
				end
			end else begin
				dec_emit = 1'b1;
				case (dec_len)
					CntW'(1): begin
						seq_ok = 1'b1;
						dec_cp = CpW'(lead[6:0]);
					end
					CntW'(2): begin
						seq_ok = cont_ok[0];
						dec_cp = CpW'({lead[4:0], buf_q[1][5:0]});
					end
					CntW'(3): begin
						seq_ok = cont_ok[0] & cont_ok[1];
						dec_cp = CpW'({lead[3:0], buf_q[1][5:0], buf_q[2][5:0]});
					end
					default: begin
						seq_ok = cont_ok[0] & cont_ok[1] & cont_ok[2];
						dec_cp = {lead[2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
					end
				endcase
				if (seq_ok) begin
					dec_drop = dec_len;
				end else begin
					dec_cp = u8d_pkg::REPLACEMENT_CP;
				end
			end
		end
	end

	// Buffer contents after dropping the consumed bytes from the front.
	always_comb begin
		logic [CntW-1:0] src;
		for (int k = 0; k < Depth; k++) begin
			src = CntW'(k) + dec_drop;
			if (src < CntW'(Depth)) begin
				shifted[k] = buf_q[src[IdxW-1:0]];
			end else begin
				shifted[k] = buf_q[k];
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign push     = (cmd.step || cmd.finish) && hold_valid_q;

	always_comb begin
		sts.emit       = dec_emit;
		sts.out_free   = out_free;
		sts.hold_valid = hold_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			fin_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (cnt_q < CntW'(Depth)) begin
					cnt_q <= cnt_q + CntW'(1);
				end
				fin_q <= final_byte;
			end
			if (cmd.step) begin
				hold_valid_q <= 1'b1;
				if (dec_clear) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q - dec_drop;
				end
			end
			if (cmd.finish) begin
				hold_valid_q <= 1'b0;
				if (fin_q) begin
					cnt_q <= '0;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < CntW'(Depth)) begin
			buf_q[cnt_q[IdxW-1:0]] <= text_byte;
		end
		if (cmd.step) begin
			hold_cp_q <= dec_cp;
			for (int k = 0; k < Depth; k++) begin
				buf_q[k] <= shifted[k];
			end
		end
		if (push) begin
			out_cp_q   <= hold_cp_q;
			out_last_q <= cmd.finish;
			out_eot_q  <= cmd.finish && fin_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_point  = out_cp_q;
	assign last_of_run = out_last_q;
	assign end_of_text = out_eot_q;

endmodule

/* rtl/core/utf8_stream_decoder.sv */
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    text_byte[7:0], final_byte
// output    out        out_valid / out_stall  code_point[20:0], last_of_run, end_of_text
//
// Each request is loaded into the buffer from the idle state; the run state then takes
// one decode step per code point it yields plus a closing step, a single decode step
// per cycle unless a held result waits for room in the output register.
// Reset clears the controller, the byte count, the final flag, the hold flag and
// the output valid flag; the buffered bytes hold no meaning until written.
// A stall on the output holds the last result in the output register and pauses
// the decode run; the input is stalled for the whole run of a byte.
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  text_byte,
	input  logic                        final_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [u8d_pkg::CpWidth-1:0] code_point,
	output logic                        last_of_run,
	output logic                        end_of_text
);

	// The controller sequences the decode run of each byte; the datapath holds
	// the pending bytes, decodes the front of the buffer, and keeps one result in
	// a hold slot so that the last result of a run can be flagged as such once
	// the following decode step shows that nothing more comes.
	u8d_pkg::u8d_cmd_t ctrl_cmd;
	u8d_pkg::u8d_sts_t dp_sts;

	u8d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (ctrl_cmd)
	);

	u8d_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.final_byte  (final_byte),
		.cmd         (ctrl_cmd),
		.sts         (dp_sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

	// The end of the text is always the last result of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_text |-> last_of_run)
		else $error("end_of_text without last_of_run");

	// A new request never finds a result still waiting in the hold slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.load |-> !dp_sts.hold_valid)
		else $error("request accepted with a held result");

	// Closing a run always empties the hold slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.finish |=> !dp_sts.hold_valid)
		else $error("hold slot not flushed at end of run");

	// A held result is never pushed over a stalled output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_cmd.step || ctrl_cmd.finish) && dp_sts.hold_valid |-> dp_sts.out_free)
		else $error("result pushed into a full output register");

endmodule

/* tb/utf8_stream_decoder_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

	localparam int CpW = u8d_pkg::CpWidth;

	// Payload masks of the lead and continuation bytes.
	localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
	localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
	localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;
	localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

	// The bound allows for the slowest correct byte in the block, the longest source
	// gap and four results each held up by the sink for its longest stall, for about
	// 400 bytes, so it leaves a wide margin.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 350;
	localparam int DRAIN_CYCLES = 16;

	typedef logic [7:0] byte_list_t[$];

	// One input request as the source will present it, with the idle cycles that
	// come before it.
	typedef struct {
		logic [7:0] text_byte;
		logic       final_byte;
		int         gap;
	} text_req_t;

	// One decoded code point as the block should deliver it.
	typedef struct {
		logic [CpW-1:0] code_point;
		logic           last_of_run;
		logic           end_of_text;
	} cp_exp_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	logic [7:0]     text_byte = 8'h00;
	logic           final_byte = 1'b0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [CpW-1:0] code_point;
	logic           last_of_run;
	logic           end_of_text;

	text_req_t text_req_q[$];
	cp_exp_t   cp_expect_q[$];

	// Shadow copy of the decoder's byte buffer.
	logic [7:0] pend_bytes[4];
	int         pend_cnt = 0;

	int  err_cnt = 0;
	int  bytes_sent = 0;
	int  texts_sent = 0;
	int  cps_checked = 0;
	int  repl_checked = 0;
	int  cycle_cnt = 0;
	int  src_wait = 0;
	int  sink_wait = 0;
	bit  src_calm = 1'b0;
	bit  sink_calm = 1'b0;

	utf8_stream_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Removes n bytes from the front of the shadow buffer.
	function automatic void drop_pending(int n);
		if (n >= pend_cnt) begin
			pend_cnt = 0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (k + n < 4)
					pend_bytes[k] = pend_bytes[k + n];
			end
			pend_cnt = pend_cnt - n;
		end
	endfunction

	// Applies one accepted byte to the shadow buffer and queues the code points it
	// yields. Decoding always starts at the front of the buffer and repeats until
	// the buffer is empty, a sequence is still incomplete, or four results are out.
	function automatic void decode_text_byte(logic [7:0] b, logic fin);
		cp_exp_t        run_q[$];
		cp_exp_t        res;
		logic [7:0]     lead;
		logic [CpW-1:0] cp;
		int             len;
		bit             ok;
		bit             stop;

		res.last_of_run = 1'b0;
		res.end_of_text = 1'b0;
		if (pend_cnt < 4) begin
			pend_bytes[pend_cnt] = b;
			pend_cnt++;
		end
		stop = 1'b0;
		while (pend_cnt > 0 && run_q.size() < 4 && !stop) begin
			lead = pend_bytes[0];
			len = 0;
			cp = '0;
			if ((lead & u8d_pkg::ASCII_MASK) == 8'h00) begin
				cp = CpW'(lead);
				len = 1;
			end else if ((lead & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_CODE) begin
				cp = CpW'(lead & LEAD2_PAYLOAD);
				len = 2;
			end else if ((lead & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_CODE) begin
				cp = CpW'(lead & LEAD3_PAYLOAD);
				len = 3;
			end else if ((lead & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_CODE) begin
				cp = CpW'(lead & LEAD4_PAYLOAD);
				len = 4;
			end

			if (len == 0) begin
				// A stray continuation byte or an impossible lead is replaced and
				// dropped on its own.
				res.code_point = u8d_pkg::REPLACEMENT_CP;
				run_q = {run_q, res};
				drop_pending(1);
			end else if (pend_cnt < len) begin
				// Not all bytes are here yet. At the end of the text the partial
				// sequence turns into one replacement and the rest is thrown away.
				if (fin) begin
					res.code_point = u8d_pkg::REPLACEMENT_CP;
					run_q = {run_q, res};
					pend_cnt = 0;
				end
				stop = 1'b1;
			end else begin
				ok = 1'b1;
				for (int k = 1; k < len; k++) begin
					if (ok) begin
						if ((pend_bytes[k] & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_CODE)
							ok = 1'b0;
						else
							cp = (cp << 6) | CpW'(pend_bytes[k] & CONT_PAYLOAD);
					end
				end
				// On a bad continuation only the lead goes, so the bytes behind it
				// are decoded again from scratch.
				res.code_point = ok ? cp : u8d_pkg::REPLACEMENT_CP;
				run_q = {run_q, res};
				drop_pending(ok ? len : 1);
			end
		end
		if (fin)
			pend_cnt = 0;

		if (run_q.size() > 0) begin
			run_q[run_q.size() - 1].last_of_run = 1'b1;
			run_q[run_q.size() - 1].end_of_text = fin;
		end
		foreach (run_q[i])
			cp_expect_q = {cp_expect_q, run_q[i]};
	endfunction

	// Queues a whole text, marking its last byte as final. The source now and then
	// switches between bursts with no gaps and bursts with random gaps.
	task automatic queue_text(input byte_list_t txt);
		text_req_t req;

		if ($urandom_range(0, 3) == 0)
			src_calm = !src_calm;
		foreach (txt[i]) begin
			req.text_byte = txt[i];
			req.final_byte = (i == txt.size() - 1);
			req.gap = src_calm ? 0 : $urandom_range(0, 8);
			text_req_q = {text_req_q, req};
		end
		texts_sent++;
	endtask

	// Source side. A new request is taken from the queue once the current one
	// has been accepted and its own gap has passed. The payload stays put while
	// the block stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= 8'h00;
			final_byte <= 1'b0;
			src_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_text_byte(text_byte, final_byte);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (text_req_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (src_wait < text_req_q[0].gap) begin
					src_wait <= src_wait + 1;
					in_valid <= 1'b0;
				end else begin
					text_byte <= text_req_q[0].text_byte;
					final_byte <= text_req_q[0].final_byte;
					in_valid <= 1'b1;
					src_wait <= 0;
					void'(text_req_q.pop_front());
				end
			end
		end
	end

	// Sink side. Every accepted code point is checked against the oldest
	// expectation, and after each one the sink draws how many cycles it stalls.
	always @(posedge clk or negedge arst_n) begin
		cp_exp_t exp_cp;
		int      hold;

		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cp_expect_q.size() == 0) begin
					$display("%0t: code point %h arrived with nothing expected",
						$time, code_point);
					err_cnt++;
				end else begin
					exp_cp = cp_expect_q.pop_front();
					if (code_point !== exp_cp.code_point) begin
						$display("%0t: code_point expected %h actual %h",
							$time, exp_cp.code_point, code_point);
						err_cnt++;
					end
					if (last_of_run !== exp_cp.last_of_run) begin
						$display("%0t: last_of_run expected %b actual %b",
							$time, exp_cp.last_of_run, last_of_run);
						err_cnt++;
					end
					if (end_of_text !== exp_cp.end_of_text) begin
						$display("%0t: end_of_text expected %b actual %b",
							$time, exp_cp.end_of_text, end_of_text);
						err_cnt++;
					end
					if (exp_cp.code_point == u8d_pkg::REPLACEMENT_CP)
						repl_checked++;
				end
				cps_checked++;
				if ($urandom_range(0, 11) == 0)
					sink_calm = !sink_calm;
				hold = sink_calm ? 0 : $urandom_range(0, 8);
				sink_wait <= hold;
				out_stall <= (hold != 0);
			end else if (sink_wait > 0) begin
				sink_wait <= sink_wait - 1;
				out_stall <= (sink_wait > 1);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests and %0d code points outstanding",
				$time, text_req_q.size(), cp_expect_q.size());
			$display("[utf8_stream_decoder] ERROR");
			$finish;
		end
	end

	initial begin
		byte_list_t txt;
		int         n_chars;
		int         kind;
		int         len;
		int         n_cont;
		int         bad_at;
		int         queued;

		// Directed texts. The first covers the smallest and largest ASCII byte and
		// one well-formed sequence of two and three bytes.
		queue_text('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
		// The largest value a four-byte lead can carry.
		queue_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
		// A stray continuation byte, an impossible lead, a bad continuation after a two-byte lead, and a text
		// cut short while the byte behind the lead is not a continuation.
		queue_text('{8'h80, 8'hFF, 8'hC3, 8'h41, 8'hF0, 8'h41});
		// A three-byte sequence cut short by the end of the text.
		queue_text('{8'hE2, 8'h82});
		// A four-byte sequence broken in its third byte; the last byte then
		// releases four replacement or plain code points at once.
		queue_text('{8'hF0, 8'h9F, 8'h41, 8'h80});
		// A text of a single byte.
		queue_text('{8'h41});

		// Random texts: mostly well-formed characters with random payload bits,
		// mixed with stray bytes, truncated sequences and bad continuations.
		queued = 0;
		while (queued < RANDOM_BYTES) begin
			txt.delete();
			n_chars = $urandom_range(1, 6);
			for (int c = 0; c < n_chars; c++) begin
				kind = $urandom_range(0, 15);
				len = (kind <= 4) ? 1 : (kind <= 7) ? 2 : (kind <= 9) ? 3 :
					(kind <= 11) ? 4 : $urandom_range(2, 4);
				if (kind == 12) begin
					txt = {txt, 8'($urandom_range(0, 255))};
				end else if (kind == 15) begin
					txt = {txt, u8d_pkg::CONT_CODE | 8'($urandom_range(0, 63))};
				end else if (len == 1) begin
					txt = {txt, 8'($urandom_range(0, 127))};
				end else begin
					case (len)
						2: txt = {txt, u8d_pkg::LEAD2_CODE | 8'($urandom_range(0, 31))};
						3: txt = {txt, u8d_pkg::LEAD3_CODE | 8'($urandom_range(0, 15))};
						default: txt = {txt, u8d_pkg::LEAD4_CODE | 8'($urandom_range(0, 7))};
					endcase
					n_cont = (kind == 13) ? $urandom_range(0, len - 2) : len - 1;
					bad_at = (kind == 14) ? $urandom_range(0, len - 2) : -1;
					for (int k = 0; k < n_cont; k++) begin
						if (k == bad_at)
							txt = {txt, 8'($urandom_range(0, 255))};
						else
							txt = {txt, u8d_pkg::CONT_CODE | 8'($urandom_range(0, 63))};
					end
				end
			end
			queued += txt.size();
			queue_text(txt);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the source to empty, then for every expected code point, then a
		// little longer so that any surplus output shows up as a failure.
		while (text_req_q.size() > 0 || in_valid)
			@(posedge clk);
		while (cp_expect_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d texts under random gaps and stalls.",
			bytes_sent, texts_sent);
		$display("Checked %0d code points, %0d of them replacements, with %0d errors.",
			cps_checked, repl_checked, err_cnt);
		if (err_cnt == 0)
			$display("[utf8_stream_decoder] OK");
		else
			$display("[utf8_stream_decoder] ERROR");
		$finish;
	end

endmodule
